// ===== design/sdl_pkg.sv =====
// Shared types, codes and sizes of the sorted descending list unit.
package sdl_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int POS_W    = 6;
   localparam int OP_W     = 3;
   localparam int ST_W     = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_EXISTS = 3'd1;
   localparam logic [OP_W-1:0] OP_POP    = 3'd2;
   localparam logic [OP_W-1:0] OP_GET    = 3'd3;
   localparam logic [OP_W-1:0] OP_SET    = 3'd4;

   localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [ST_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [ST_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] STATUS_RANGE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_HEAD,
      ST_INS_TAIL,
      ST_INS_SCAN,
      ST_SH_RD,
      ST_SH_WR,
      ST_INS_WRITE,
      ST_EX_SCAN,
      ST_POP_DATA,
      ST_GET_DATA,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {RD_NONE, RD_NEXT, RD_LAST, RD_POS, RD_PREV} rd_sel_type;
   typedef enum logic [1:0] {WR_NONE, WR_POS_VALUE, WR_AT_VALUE, WR_IDX_DATA} wr_sel_type;
   typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_ONE, IDX_INC, IDX_DEC, IDX_COUNT} idx_op_type;
   typedef enum logic [1:0] {AT_HOLD, AT_ZERO, AT_COUNT, AT_IDX} at_op_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_type;

   typedef struct packed {
      logic             take_req;
      rd_sel_type       rd_sel;
      wr_sel_type       wr_sel;
      idx_op_type       idx_op;
      at_op_type        at_op;
      cnt_op_type       cnt_op;
      logic             status_en;
      logic [ST_W-1:0]  status;
      logic             found_set;
      logic             vout_load;
      logic             rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            full;
      logic            empty;
      logic            pos_oob;
      logic            head_le;
      logic            tail_ge;
      logic            scan_gt;
      logic            match;
      logic            idx_last;
      logic            sh_done;
   } stat_type;

endpackage

// ===== design/sdl_req_if.sv =====
// Request and response channel interfaces of the sorted descending list unit.
interface sdl_req_if import sdl_pkg::*; #(parameter int DATA_WIDTH = 32) ();
   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              opcode;
   logic signed [DATA_WIDTH-1:0] value;
   logic [POS_W-1:0]             position;

   modport source (output valid, opcode, value, position, input ready);
   modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface sdl_rsp_if import sdl_pkg::*; #(parameter int DATA_WIDTH = 32) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] value_out;
   logic                         found;
   logic [CNT_W-1:0]             entry_count;
   logic [ST_W-1:0]              status;

   modport source (output valid, value_out, found, entry_count, status, input ready);
   modport sink   (input valid, value_out, found, entry_count, status, output ready);
endinterface

// ===== design/sdl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sdl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sdl_ctrl.sv =====
// Controller state machine of the sorted descending list unit.
module sdl_ctrl import sdl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (stat.opcode)
               OP_INSERT: begin
                  if (stat.full)       state_in = ST_RESP;
                  else if (stat.empty) state_in = ST_INS_WRITE;
                  else                 state_in = ST_INS_HEAD;
               end
               OP_EXISTS: state_in = stat.empty ? ST_RESP : ST_EX_SCAN;
               OP_POP:    state_in = stat.empty ? ST_RESP : ST_POP_DATA;
               OP_GET:    state_in = stat.pos_oob ? ST_RESP : ST_GET_DATA;
               default:   state_in = ST_RESP;
            endcase
         end
         ST_INS_HEAD: state_in = stat.head_le ? ST_SH_RD : ST_INS_TAIL;
         ST_INS_TAIL: state_in = stat.tail_ge ? ST_INS_WRITE : ST_INS_SCAN;
         ST_INS_SCAN: begin
            if (!stat.scan_gt) state_in = ST_SH_RD;
         end
         ST_SH_RD:     state_in = stat.sh_done ? ST_INS_WRITE : ST_SH_WR;
         ST_SH_WR:     state_in = ST_SH_RD;
         ST_INS_WRITE: state_in = ST_RESP;
         ST_EX_SCAN: begin
            if (stat.match || stat.idx_last) state_in = ST_RESP;
         end
         ST_POP_DATA: state_in = ST_RESP;
         ST_GET_DATA: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.rd_sel    = RD_NONE;
      cmd.wr_sel    = WR_NONE;
      cmd.idx_op    = IDX_HOLD;
      cmd.at_op     = AT_HOLD;
      cmd.cnt_op    = CNT_HOLD;
      cmd.status    = STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take_req = req_valid;
         end
         ST_DECODE: begin
            unique case (stat.opcode)
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.status_en = 1'b1;
                     cmd.status    = STATUS_FULL;
                  end else if (stat.empty) begin
                     cmd.at_op = AT_ZERO;
                  end else begin
                     cmd.idx_op = IDX_ZERO;
                     cmd.rd_sel = RD_NEXT;
                  end
               end
               OP_EXISTS: begin
                  if (!stat.empty) begin
                     cmd.idx_op = IDX_ZERO;
                     cmd.rd_sel = RD_NEXT;
                  end
               end
               OP_POP: begin
                  if (stat.empty) begin
                     cmd.status_en = 1'b1;
                     cmd.status    = STATUS_EMPTY;
                  end else begin
                     cmd.rd_sel = RD_LAST;
                  end
               end
               OP_GET: begin
                  if (stat.pos_oob) begin
                     cmd.status_en = 1'b1;
                     cmd.status    = STATUS_RANGE;
                  end else begin
                     cmd.rd_sel = RD_POS;
                  end
               end
               OP_SET: begin
                  if (stat.pos_oob) begin
                     cmd.status_en = 1'b1;
                     cmd.status    = STATUS_RANGE;
                  end else begin
                     cmd.wr_sel = WR_POS_VALUE;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_INS_HEAD: begin
            if (stat.head_le) begin
               cmd.at_op  = AT_ZERO;
               cmd.idx_op = IDX_COUNT;
            end else begin
               cmd.rd_sel = RD_LAST;
            end
         end
         ST_INS_TAIL: begin
            if (stat.tail_ge) begin
               cmd.at_op = AT_COUNT;
            end else begin
               cmd.idx_op = IDX_ONE;
               cmd.rd_sel = RD_NEXT;
            end
         end
         ST_INS_SCAN: begin
            if (stat.scan_gt) begin
               cmd.idx_op = IDX_INC;
               cmd.rd_sel = RD_NEXT;
            end else begin
               cmd.at_op  = AT_IDX;
               cmd.idx_op = IDX_COUNT;
            end
         end
         ST_SH_RD: begin
            if (!stat.sh_done) cmd.rd_sel = RD_PREV;
         end
         ST_SH_WR: begin
            cmd.wr_sel = WR_IDX_DATA;
            cmd.idx_op = IDX_DEC;
         end
         ST_INS_WRITE: begin
            cmd.wr_sel = WR_AT_VALUE;
            cmd.cnt_op = CNT_INC;
         end
         ST_EX_SCAN: begin
            if (stat.match) begin
               cmd.found_set = 1'b1;
            end else if (!stat.idx_last) begin
               cmd.idx_op = IDX_INC;
               cmd.rd_sel = RD_NEXT;
            end
         end
         ST_POP_DATA: begin
            cmd.vout_load = 1'b1;
            cmd.cnt_op    = CNT_DEC;
         end
         ST_GET_DATA: begin
            cmd.vout_load = 1'b1;
         end
         ST_RESP: begin
            cmd.rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)  rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/sdl_dpath.sv =====
// Datapath of the sorted descending list unit: entry store, pointers, result registers.
module sdl_dpath import sdl_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output stat_type                     stat,
   input  logic [OP_W-1:0]              req_opcode,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic [POS_W-1:0]             req_position,
   output logic signed [DATA_WIDTH-1:0] rsp_value_out,
   output logic                         rsp_found,
   output logic [CNT_W-1:0]             rsp_entry_count,
   output logic [ST_W-1:0]              rsp_status
);

   logic [OP_W-1:0]              opcode_ff;
   logic signed [DATA_WIDTH-1:0] value_ff;
   logic [POS_W-1:0]             pos_ff;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic [CNT_W-1:0]             at_ff, at_in;
   logic signed [DATA_WIDTH-1:0] vout_ff;
   logic                         found_ff;
   logic [ST_W-1:0]              status_ff;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff;
   logic                         rsp_found_ff;
   logic [CNT_W-1:0]             rsp_count_ff;
   logic [ST_W-1:0]              rsp_status_ff;

   logic                  rd_en, wr_en;
   logic [IDX_W-1:0]      rd_addr, wr_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   logic signed [DATA_WIDTH-1:0] rd_sv;
   logic [CNT_W-1:0]      last_idx, prev_idx;

   assign rd_sv    = $signed(rd_data);
   assign last_idx = count_ff - CNT_W'(1);
   assign prev_idx = idx_ff - CNT_W'(1);

   always_comb begin
      unique case (cmd.idx_op)
         IDX_ZERO:  idx_in = '0;
         IDX_ONE:   idx_in = CNT_W'(1);
         IDX_INC:   idx_in = idx_ff + CNT_W'(1);
         IDX_DEC:   idx_in = prev_idx;
         IDX_COUNT: idx_in = count_ff;
         default:   idx_in = idx_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.at_op)
         AT_ZERO:  at_in = '0;
         AT_COUNT: at_in = count_ff;
         AT_IDX:   at_in = idx_ff;
         default:  at_in = at_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = last_idx;
         default: count_in = count_ff;
      endcase
   end

   always_comb begin
      rd_en   = 1'b1;
      unique case (cmd.rd_sel)
         RD_NEXT: rd_addr = idx_in[IDX_W-1:0];
         RD_LAST: rd_addr = last_idx[IDX_W-1:0];
         RD_POS:  rd_addr = IDX_W'(pos_ff);
         RD_PREV: rd_addr = prev_idx[IDX_W-1:0];
         default: begin
            rd_en   = 1'b0;
            rd_addr = '0;
         end
      endcase
   end

   always_comb begin
      wr_en = 1'b1;
      unique case (cmd.wr_sel)
         WR_POS_VALUE: begin
            wr_addr = IDX_W'(pos_ff);
            wr_data = value_ff;
         end
         WR_AT_VALUE: begin
            wr_addr = at_ff[IDX_W-1:0];
            wr_data = value_ff;
         end
         WR_IDX_DATA: begin
            wr_addr = idx_ff[IDX_W-1:0];
            wr_data = rd_data;
         end
         default: begin
            wr_en   = 1'b0;
            wr_addr = '0;
            wr_data = value_ff;
         end
      endcase
   end

   sdl_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.opcode   = opcode_ff;
      stat.full     = (count_ff == CNT_W'(CAPACITY));
      stat.empty    = (count_ff == '0);
      stat.pos_oob  = (CNT_W'(pos_ff) >= count_ff);
      stat.head_le  = !(rd_sv > value_ff);
      stat.tail_ge  = !(value_ff > rd_sv);
      stat.scan_gt  = (rd_sv > value_ff);
      stat.match    = (rd_sv == value_ff);
      stat.idx_last = ((idx_ff + CNT_W'(1)) == count_ff);
      stat.sh_done  = (idx_ff == at_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      at_ff  <= at_in;
      if (cmd.take_req) begin
         opcode_ff <= req_opcode;
         value_ff  <= req_value;
         pos_ff    <= req_position;
         vout_ff   <= '0;
         found_ff  <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         if (cmd.vout_load) vout_ff   <= rd_sv;
         if (cmd.found_set) found_ff  <= 1'b1;
         if (cmd.status_en) status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff  <= vout_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_value_out   = rsp_value_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== design/sorted_descending_list_unit.sv =====
// Top level of the sorted descending list unit: controller, datapath and channel wiring.
//
//   Channel   Direction  Payload
//   req_bus   in         opcode, value, position
//   rsp_bus   out        value_out, found, entry_count, status
//
// One request at a time. Insert writes at the head, the tail or the place a scan finds,
// after each entry behind it is shifted back by a read then a write of the registered-read
// entry RAM; a full list answers FULL. Exists scans to a match or the last entry. Pop and
// get read one entry, set writes one; errors and unused codes go straight to the response.
// Synchronous reset empties the list; no clearing pass.
// A stalled response holds in its register while the next request is already taken.
module sorted_descending_list_unit import sdl_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input logic     clock,
   input logic     reset,
   sdl_req_if.sink req_bus,
   sdl_rsp_if.source rsp_bus
);

   cmd_type  cmd;
   stat_type stat;

   sdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sdl_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_bus.opcode),
      .req_value       (req_bus.value),
      .req_position    (req_bus.position),
      .rsp_value_out   (rsp_bus.value_out),
      .rsp_found       (rsp_bus.found),
      .rsp_entry_count (rsp_bus.entry_count),
      .rsp_status      (rsp_bus.status)
   );

endmodule

// ===== tb/sorted_descending_list_unit_tb.sv =====
// Self-checking testbench of the sorted descending list unit.
module sorted_descending_list_unit_tb import sdl_pkg::*; ();

   localparam int DW = 32;

   localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

   localparam logic signed [DW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;

   localparam int ITEMS_PER_PHASE = 667;
   localparam int DRAIN_CYCLES    = 200;
   localparam int MAX_PRINTS      = 40;

   typedef struct packed {
      logic signed [DW-1:0] value_out;
      logic                 found;
      logic [CNT_W-1:0]     entry_count;
      logic [ST_W-1:0]      status;
   } list_result_type;

   class sorted_list_tracker;
      logic signed [DW-1:0] slots [CAPACITY];
      int                   held;
      list_result_type      pending_results[$];
      int                   failures;
      int                   checked;
      int                   printed;
      int                   op_seen[8];
      int                   status_seen[4];
      int                   hits;
      int                   peak;

      function void note_request(input logic [OP_W-1:0] op, input logic signed [DW-1:0] val,
                                 input logic [POS_W-1:0] pos);
         list_result_type r;
         int              at;
         r = '0;
         case (op)
            OP_INSERT: begin
               if (held >= CAPACITY) begin
                  r.status = STATUS_FULL;
               end else begin
                  if (held == 0 || !(slots[0] > val)) begin
                     at = 0;
                  end else if (!(val > slots[held-1])) begin
                     at = held;
                  end else begin
                     at = 0;
                     while (at < held && slots[at] > val) at++;
                  end
                  for (int i = held; i > at; i--) slots[i] = slots[i-1];
                  slots[at] = val;
                  held++;
               end
            end
            OP_EXISTS: begin
               for (int i = 0; i < held; i++) begin
                  if (slots[i] == val) r.found = 1'b1;
               end
            end
            OP_POP: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.value_out = slots[held-1];
                  held--;
               end
            end
            OP_GET: begin
               if (pos >= held) r.status = STATUS_RANGE;
               else r.value_out = slots[pos];
            end
            OP_SET: begin
               if (pos >= held) r.status = STATUS_RANGE;
               else slots[pos] = val;
            end
            default: ;
         endcase
         r.entry_count = held[CNT_W-1:0];
         if (held > peak) peak = held;
         op_seen[op]++;
         status_seen[r.status]++;
         if (r.found) hits++;
         pending_results.push_back(r);
      endfunction

      function void mismatch(input string field, input logic signed [DW-1:0] want,
                             input logic signed [DW-1:0] got);
         failures++;
         if (printed < MAX_PRINTS) begin
            printed++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_response(input logic signed [DW-1:0] value_out, input logic found,
                                   input logic [CNT_W-1:0] entry_count,
                                   input logic [ST_W-1:0] status);
         list_result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (printed < MAX_PRINTS) begin
               printed++;
               $display("%0t: unexpected response, expected none, actual count %0d status %0d",
                        $time, entry_count, status);
            end
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (value_out !== want.value_out) mismatch("value_out", want.value_out, value_out);
         if (found !== want.found) mismatch("found", want.found, found);
         if (entry_count !== want.entry_count)
            mismatch("entry_count", want.entry_count, entry_count);
         if (status !== want.status) mismatch("status", want.status, status);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct;
   int   rsp_idle_pct;

   sorted_list_tracker tracker;

   sdl_req_if #(.DATA_WIDTH(DW)) req_bus ();
   sdl_rsp_if #(.DATA_WIDTH(DW)) rsp_bus ();

   sorted_descending_list_unit #(.DATA_WIDTH(DW)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         tracker.check_response(rsp_bus.value_out, rsp_bus.found, rsp_bus.entry_count,
                                rsp_bus.status);
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DW-1:0] val,
                               input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op;
      req_bus.value    <= val;
      req_bus.position <= pos;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      tracker.note_request(op, val, pos);
   endtask

   function automatic logic signed [DW-1:0] pick_value();
      int near;
      near = $urandom_range(16);
      case ($urandom_range(9))
         0, 1, 2, 3: return near - 8;
         4: begin
            case ($urandom_range(3))
               0: return VAL_MAX;
               1: return VAL_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic random_request(input bit filling, output bit useful);
      logic [OP_W-1:0]      op;
      logic signed [DW-1:0] val;
      logic [POS_W-1:0]     pos;
      int                   r;
      int                   cut_ins, cut_ex, cut_pop, cut_get;
      if (filling) begin
         cut_ins = 60; cut_ex = 72; cut_pop = 78; cut_get = 87;
      end else begin
         cut_ins = 15; cut_ex = 30; cut_pop = 75; cut_get = 85;
      end
      r = $urandom_range(99);
      if (r < cut_ins) op = OP_INSERT;
      else if (r < cut_ex) op = OP_EXISTS;
      else if (r < cut_pop) op = OP_POP;
      else if (r < cut_get) op = OP_GET;
      else if (r < 96) op = OP_SET;
      else begin
         case ($urandom_range(2))
            0: op = OP_RSVD_A;
            1: op = OP_RSVD_B;
            default: op = OP_RSVD_C;
         endcase
      end
      val = pick_value();
      if (op == OP_EXISTS && tracker.held > 0 && $urandom_range(9) < 6)
         val = tracker.slots[$urandom_range(tracker.held - 1)];
      if (tracker.held > 0 && $urandom_range(9) < 7)
         pos = POS_W'($urandom_range(tracker.held - 1));
      else
         pos = POS_W'($urandom_range(63));
      useful = (op <= OP_SET);
      send_request(op, val, pos);
   endtask

   initial begin
      int  useful;
      int  seg;
      bit  filling;
      bit  u;
      tracker          = new();
      req_bus.valid    <= 1'b0;
      req_bus.opcode   <= OP_INSERT;
      req_bus.value    <= '0;
      req_bus.position <= '0;
      send_idle_pct = 25;
      rsp_idle_pct  = 56;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_POP,    '0,      '0);
      send_request(OP_EXISTS, '0,      '0);
      send_request(OP_GET,    '0,      '0);
      send_request(OP_SET,    32'sd9,  '0);
      send_request(OP_RSVD_A, VAL_MAX, '1);
      send_request(OP_RSVD_B, VAL_MIN, '0);
      send_request(OP_RSVD_C, '1,      '1);
      send_request(OP_INSERT, '0,      '0);
      send_request(OP_INSERT, '0,      '1);
      send_request(OP_INSERT, VAL_MAX, '0);
      send_request(OP_INSERT, VAL_MIN, '0);
      send_request(OP_INSERT, 32'sd5,  '0);
      send_request(OP_INSERT, -32'sd5, '0);
      send_request(OP_EXISTS, '0,      '0);
      send_request(OP_EXISTS, 32'sd7,  '0);
      send_request(OP_EXISTS, VAL_MIN, '0);
      send_request(OP_GET,    '0,      6'd0);
      send_request(OP_GET,    '0,      6'd5);
      send_request(OP_GET,    '0,      6'd6);
      send_request(OP_GET,    '0,      6'd63);
      send_request(OP_SET,    -32'sd100, 6'd1);
      send_request(OP_INSERT, 32'sd3,  '0);
      send_request(OP_POP,    '0,      '0);
      send_request(OP_SET,    VAL_MAX, 6'd63);
      send_request(OP_POP,    '0,      '0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 25; rsp_idle_pct = 56; end
            1: begin send_idle_pct = 56; rsp_idle_pct = 25; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         useful  = 0;
         filling = 1'b1;
         while (useful < ITEMS_PER_PHASE) begin
            seg = $urandom_range(140, 60);
            for (int k = 0; k < seg && useful < ITEMS_PER_PHASE; k++) begin
               random_request(filling, u);
               useful += u;
            end
            filling = !filling;
         end
      end
      req_bus.valid <= 1'b0;

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d insert, %0d exists, %0d pop, %0d get, %0d set, %0d unused; %0d checked.",
               tracker.op_seen[OP_INSERT], tracker.op_seen[OP_EXISTS], tracker.op_seen[OP_POP],
               tracker.op_seen[OP_GET], tracker.op_seen[OP_SET],
               tracker.op_seen[OP_RSVD_A] + tracker.op_seen[OP_RSVD_B] +
               tracker.op_seen[OP_RSVD_C], tracker.checked);
      $display("List peaked at %0d of %0d; %0d full, %0d empty, %0d out of range, %0d keys found.",
               tracker.peak, CAPACITY, tracker.status_seen[STATUS_FULL],
               tracker.status_seen[STATUS_EMPTY], tracker.status_seen[STATUS_RANGE],
               tracker.hits);
      if (tracker.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", tracker.pending_results.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sorted_descending_list_unit.f =====
design/sdl_pkg.sv
design/sdl_req_if.sv
design/sdl_ram.sv
design/sdl_ctrl.sv
design/sdl_dpath.sv
design/sorted_descending_list_unit.sv
tb/sorted_descending_list_unit_tb.sv
